// ===== design/mtg_pkg.sv =====
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared constants, types and word functions of the Mersenne twister block.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned MT_WORDS = 624;
  localparam int unsigned MT_SHIFT = 397;
  localparam int unsigned CNT_W    = $clog2(MT_WORDS);

  localparam logic [31:0] MT_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] MT_UPPER  = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER  = 32'h7FFF_FFFF;
  localparam logic [31:0] LCG_MUL   = 32'd69069;
  localparam logic [31:0] HALF_MASK = 32'hFFFF_0000;
  localparam logic [31:0] TEMPER_B  = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C  = 32'hEFC6_0000;

  // two LCG steps folded into one: s'' = MUL^2 * s + (MUL + 1)
  localparam logic [63:0] LCG_SQ64  = 64'(LCG_MUL) * 64'(LCG_MUL);
  localparam logic [31:0] LCG_MUL2  = LCG_SQ64[31:0];
  localparam logic [31:0] LCG_INC2  = LCG_MUL + 32'd1;

  typedef logic [31:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // item codes on the action field
  typedef enum logic {
    ACT_SEED = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEED = 2'b10
  } state_t;

  // next word of the recurrence from x[i], x[i+1] and x[i+397]
  function automatic word_t twist_word(word_t x0, word_t x1, word_t xm);
    word_t y;
    word_t v;
    y = (x0 & MT_UPPER) | (x1 & MT_LOWER);
    v = xm ^ (y >> 1);
    if (y[0]) begin
      v = v ^ MT_MATRIX;
    end
    return v;
  endfunction

  function automatic word_t temper(word_t x);
    word_t y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mtg_in_if.sv =====
// ----------------------------------------------------------------------------
// mtg_in_if
// Request channel: seed or draw item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] seed_value;
  logic [31:0] range_limit;

  modport source (output valid, output action, output seed_value,
                  output range_limit, input ready);
  modport sink   (input valid, input action, input seed_value,
                  input range_limit, output ready);
endinterface

// ===== design/mtg_out_if.sv =====
// ----------------------------------------------------------------------------
// mtg_out_if
// Result channel: tempered word, scaled value and unseeded flag.
// ----------------------------------------------------------------------------
interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;
  logic [31:0] scaled_value;
  logic        not_seeded;

  modport source (output valid, output random_word, output scaled_value,
                  output not_seeded, input ready);
  modport sink   (input valid, input random_word, input scaled_value,
                  input not_seeded, output ready);
endinterface

// ===== design/mersenne_twister_generator.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 random word source with 69069 LCG seeding and range scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries items: action 0 loads seed_value, action 1 draws a word.
//   out_chan returns one item per draw: tempered word, (word*range_limit)>>32
//   and not_seeded. A seed returns nothing.
//   State is a chain of 624 word cells. Each seeded draw twists one word
//   from the head cells (0, 1, 397), emits it tempered and shifts it into
//   the tail, so no bulk twist pass ever runs.
// Throughput: one draw per cycle unless a seed runs or out_chan stalls.
//   A seed walks the LCG through the chain, one word per cycle, and
//   in_chan.ready stays low until it ends. Pipeline: twist/temper stage,
//   then the scaling multiply stage, whose register drives out_chan.
// Reset: control clears, the block is unseeded; draws then return zero with
//   not_seeded set. Cell contents are undefined until the first seed.
// Stall: results wait in the output register; one more draw waits in the
//   temper stage, then in_chan.ready drops until out_chan.ready returns.
// ----------------------------------------------------------------------------
module mersenne_twister_generator (
  input  logic      clk,
  input  logic      rst_n,
  mtg_in_if.sink    in_chan,
  mtg_out_if.source out_chan
);

  // --- control ---
  mtg_pkg::state_t state_r, state_nxt;
  mtg_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            seeded_r, seeded_nxt;

  // --- temper stage ---
  logic            a_vld_r, a_vld_nxt;
  mtg_pkg::word_t  a_word_r, a_word_nxt;
  mtg_pkg::word_t  a_lim_r, a_lim_nxt;
  logic            a_ns_r, a_ns_nxt;

  // --- output stage ---
  logic            o_vld_r, o_vld_nxt;
  mtg_pkg::word_t  o_word_r, o_word_nxt;
  mtg_pkg::word_t  o_scaled_r, o_scaled_nxt;
  logic            o_ns_r, o_ns_nxt;

  logic            o_move;
  logic            a_free;
  logic            in_acc;
  logic            seed_acc;
  logic            draw_acc;
  logic            seeding;
  logic            shift_en;
  mtg_pkg::word_t  lcg_word;
  mtg_pkg::word_t  new_word;
  mtg_pkg::word_t  tail_word;
  logic [63:0]     product;

  mtg_pkg::word_t  cell_q [mtg_pkg::MT_WORDS];

  // handshake
  assign o_move   = a_vld_r && (!o_vld_r || out_chan.ready);
  assign a_free   = !a_vld_r || o_move;
  assign in_chan.ready = (state_r == mtg_pkg::ST_IDLE) && a_free;
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign seed_acc = in_acc && (in_chan.action == mtg_pkg::ACT_SEED);
  assign draw_acc = in_acc && (in_chan.action == mtg_pkg::ACT_DRAW);
  assign seeding  = (state_r == mtg_pkg::ST_SEED);

  // chain moves on every seed cycle and on every seeded draw
  assign shift_en  = seeding || (draw_acc && seeded_r);
  assign new_word  = mtg_pkg::twist_word(cell_q[0], cell_q[1], cell_q[mtg_pkg::MT_SHIFT]);
  assign tail_word = seeding ? lcg_word : new_word;

  mtg_lcg u_lcg (
    .clk  (clk),
    .load (seed_acc),
    .step (seeding),
    .seed (in_chan.seed_value),
    .word (lcg_word)
  );

  // cell 0 is the oldest word, the last cell takes the fresh one
  genvar gi;
  generate
    for (gi = 0; gi < mtg_pkg::MT_WORDS; gi++) begin : g_cell
      if (gi == mtg_pkg::MT_WORDS - 1) begin : g_tail
        mtg_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d_in     (tail_word),
          .q        (cell_q[gi])
        );
      end else begin : g_body
        mtg_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .d_in     (cell_q[gi+1]),
          .q        (cell_q[gi])
        );
      end
    end
  endgenerate

  // seed sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    seeded_nxt = seeded_r;
    case (state_r)
      mtg_pkg::ST_IDLE: begin
        if (seed_acc) begin
          state_nxt  = mtg_pkg::ST_SEED;
          cnt_nxt    = '0;
          seeded_nxt = 1'b1;
        end
      end
      mtg_pkg::ST_SEED: begin
        if (cnt_r == mtg_pkg::cnt_t'(mtg_pkg::MT_WORDS - 1)) begin
          state_nxt = mtg_pkg::ST_IDLE;
        end
        cnt_nxt = cnt_r + mtg_pkg::cnt_t'(1);
      end
      default: begin
        state_nxt = mtg_pkg::ST_IDLE;
      end
    endcase
  end

  // temper stage: unseeded draws carry zero word and zero limit
  always_comb begin
    a_vld_nxt  = a_vld_r;
    a_word_nxt = a_word_r;
    a_lim_nxt  = a_lim_r;
    a_ns_nxt   = a_ns_r;
    if (o_move) begin
      a_vld_nxt = 1'b0;
    end
    if (draw_acc) begin
      a_vld_nxt = 1'b1;
      a_ns_nxt  = !seeded_r;
      if (seeded_r) begin
        a_word_nxt = mtg_pkg::temper(new_word);
        a_lim_nxt  = in_chan.range_limit;
      end else begin
        a_word_nxt = '0;
        a_lim_nxt  = '0;
      end
    end
  end

  // output stage: scaling multiply
  assign product = 64'(a_word_r) * 64'(a_lim_r);

  always_comb begin
    o_vld_nxt    = o_vld_r;
    o_word_nxt   = o_word_r;
    o_scaled_nxt = o_scaled_r;
    o_ns_nxt     = o_ns_r;
    if (o_vld_r && out_chan.ready) begin
      o_vld_nxt = 1'b0;
    end
    if (o_move) begin
      o_vld_nxt    = 1'b1;
      o_word_nxt   = a_word_r;
      o_scaled_nxt = product[63:32];
      o_ns_nxt     = a_ns_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mtg_pkg::ST_IDLE;
      cnt_r    <= '0;
      seeded_r <= 1'b0;
      a_vld_r  <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      seeded_r <= seeded_nxt;
      a_vld_r  <= a_vld_nxt;
      o_vld_r  <= o_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_word_r   <= a_word_nxt;
    a_lim_r    <= a_lim_nxt;
    a_ns_r     <= a_ns_nxt;
    o_word_r   <= o_word_nxt;
    o_scaled_r <= o_scaled_nxt;
    o_ns_r     <= o_ns_nxt;
  end

  assign out_chan.valid        = o_vld_r;
  assign out_chan.random_word  = o_word_r;
  assign out_chan.scaled_value = o_scaled_r;
  assign out_chan.not_seeded   = o_ns_r;

endmodule

// ===== design/mtg_cell.sv =====
// ----------------------------------------------------------------------------
// mtg_cell
// One state word of the shift chain; takes its neighbor's word on shift.
// ----------------------------------------------------------------------------
module mtg_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  mtg_pkg::word_t d_in,
  output mtg_pkg::word_t q
);

  mtg_pkg::word_t word_r;
  mtg_pkg::word_t word_nxt;

  assign word_nxt = shift_en ? d_in : word_r;

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign q = word_r;

endmodule

// ===== design/mtg_lcg.sv =====
// ----------------------------------------------------------------------------
// mtg_lcg
// 69069 LCG seeder: one state word per step, two LCG steps per word.
// ----------------------------------------------------------------------------
module mtg_lcg (
  input  logic           clk,
  input  logic           load,
  input  logic           step,
  input  mtg_pkg::word_t seed,
  output mtg_pkg::word_t word
);

  mtg_pkg::word_t s_r;
  mtg_pkg::word_t s_nxt;
  mtg_pkg::word_t s_one;
  mtg_pkg::word_t s_two;

  // both multiplies read s_r directly
  assign s_one = mtg_pkg::word_t'(mtg_pkg::LCG_MUL * s_r) + 32'd1;
  assign s_two = mtg_pkg::word_t'(mtg_pkg::LCG_MUL2 * s_r) + mtg_pkg::LCG_INC2;

  assign word = (s_r & mtg_pkg::HALF_MASK) | ((s_one & mtg_pkg::HALF_MASK) >> 16);

  always_comb begin
    s_nxt = s_r;
    if (load) begin
      s_nxt = seed;
    end else if (step) begin
      s_nxt = s_two;
    end
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the Mersenne twister block: seed and draw items go in on in_chan,
// and every draw result is checked field by field against a bit-accurate
// generator model. The model is fed from the input handshakes. Both sides
// idle in random bursts, and one long result stall forces back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one expected draw result
  typedef struct packed {
    mtg_pkg::word_t word;
    mtg_pkg::word_t scaled;
    logic           unseeded;
  } draw_result_t;

  localparam int unsigned ITEM_GOAL  = 1000;  // random items
  localparam int unsigned QUIET_TAIL = 150;   // last items run with no idling
  localparam int unsigned LONG_HOLD  = 150;   // long result stall, in cycles
  localparam int unsigned DRAIN_CAP  = 5000;

  // --------------------------------------------------------------------------
  // Generator model and result store. Draws are predicted in order of
  // acceptance; results leave the block in that same order.
  // --------------------------------------------------------------------------
  class mt_stream_board_t;
    mtg_pkg::word_t pool [mtg_pkg::MT_WORDS];
    int unsigned    pos;
    bit             seeded;
    draw_result_t   expected_draws [$];
    int unsigned    mismatches;
    int unsigned    draws_checked;
    int unsigned    seeds_taken;
    int unsigned    unseeded_draws;
    int unsigned    wraps;
    int unsigned    zero_limits;

    function new();
      foreach (pool[i]) pool[i] = '0;
      pos = 0;
      seeded = 0;
    endfunction

    // full regeneration of the 624-word pool
    function void regen_pool();
      mtg_pkg::word_t y;
      mtg_pkg::word_t v;
      int unsigned    nxt;
      int unsigned    far;
      for (int unsigned k = 0; k < mtg_pkg::MT_WORDS; k++) begin
        nxt = (k + 1) % mtg_pkg::MT_WORDS;
        far = (k + mtg_pkg::MT_SHIFT) % mtg_pkg::MT_WORDS;
        y = (pool[k] & mtg_pkg::MT_UPPER) | (pool[nxt] & mtg_pkg::MT_LOWER);
        v = pool[far] ^ (y >> 1);
        if (y[0]) begin
          v = v ^ mtg_pkg::MT_MATRIX;
        end
        pool[k] = v;
      end
    endfunction

    function mtg_pkg::word_t apply_temper(mtg_pkg::word_t x);
      mtg_pkg::word_t t;
      t = x;
      t = t ^ (t >> 11);
      t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
      t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
      t = t ^ (t >> 18);
      return t;
    endfunction

    // two LCG steps per word, high halves kept
    function void load_seed(mtg_pkg::word_t seed);
      mtg_pkg::word_t s;
      mtg_pkg::word_t w;
      s = seed;
      for (int unsigned k = 0; k < mtg_pkg::MT_WORDS; k++) begin
        w = s & mtg_pkg::HALF_MASK;
        s = mtg_pkg::LCG_MUL * s + 32'd1;
        w = w | ((s & mtg_pkg::HALF_MASK) >> 16);
        s = mtg_pkg::LCG_MUL * s + 32'd1;
        pool[k] = w;
      end
      regen_pool();
      pos = 0;
      seeded = 1;
    endfunction

    function void note_request(mtg_pkg::action_t act, mtg_pkg::word_t seed,
                               mtg_pkg::word_t lim);
      draw_result_t r;
      logic [63:0]  prod;
      if (act == mtg_pkg::ACT_SEED) begin
        load_seed(seed);
        seeds_taken++;
        return;
      end
      if (!seeded) begin
        r.word = '0;
        r.scaled = '0;
        r.unseeded = 1'b1;
        unseeded_draws++;
      end else begin
        if (pos >= mtg_pkg::MT_WORDS) begin
          regen_pool();
          pos = 0;
          wraps++;
        end
        r.word = apply_temper(pool[pos]);
        pos++;
        prod = {32'd0, r.word} * {32'd0, lim};
        r.scaled = prod[63:32];
        r.unseeded = 1'b0;
        if (lim == '0) zero_limits++;
      end
      expected_draws.push_back(r);
    endfunction

    function void check_draw(mtg_pkg::word_t word, mtg_pkg::word_t scaled,
                             logic unseeded);
      draw_result_t e;
      if (expected_draws.size() == 0) begin
        $error("result with nothing expected: random_word %h", word);
        mismatches++;
        return;
      end
      e = expected_draws.pop_front();
      draws_checked++;
      if (word !== e.word) begin
        $error("random_word: expected %h, got %h", e.word, word);
        mismatches++;
      end
      if (scaled !== e.scaled) begin
        $error("scaled_value: expected %h, got %h", e.scaled, scaled);
        mismatches++;
      end
      if (unseeded !== e.unseeded) begin
        $error("not_seeded: expected %b, got %b", e.unseeded, unseeded);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_draws.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  mtg_in_if  in_chan ();
  mtg_out_if out_chan ();

  mersenne_twister_generator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mt_stream_board_t board;
  bit               idle_enabled = 1'b1;  // cleared for the quiet tail
  bit               hold_request = 1'b0;  // driver asks the sink for a long stall
  int unsigned      items_sent   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case the handshake hangs
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge. The output is checked
  // before the input is noted; a result can only belong to an earlier item.
  // --------------------------------------------------------------------------
  initial board = new();

  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        board.check_draw(out_chan.random_word, out_chan.scaled_value,
                         out_chan.not_seeded);
      end
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) begin
        board.note_request(mtg_pkg::action_t'(in_chan.action),
                           in_chan.seed_value, in_chan.range_limit);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: ready toggles in random bursts, changed at the falling edge.
  // One long stall on request lets the pipeline fill and block the input.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    logic        level;
    int unsigned span;
    out_chan.ready = 1'b0;
    @(negedge clk);
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        level = 1'b0;
        span = LONG_HOLD;
      end else if (!idle_enabled || $urandom_range(0, 3) != 0) begin
        level = 1'b1;
        span = $urandom_range(1, 20);
      end else begin
        level = 1'b0;
        span = $urandom_range(1, 7);
      end
      out_chan.ready <= level;
      repeat (span) @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Item driver: called at a falling edge, returns at the falling edge after
  // the item was taken. An optional idle burst goes before the item.
  // --------------------------------------------------------------------------
  task automatic offer_item(mtg_pkg::action_t act, mtg_pkg::word_t seed,
                            mtg_pkg::word_t lim);
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= act;
    in_chan.seed_value  <= seed;
    in_chan.range_limit <= lim;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // range limits: zero, all ones, small, single bit, or anything
  function automatic mtg_pkg::word_t pick_limit();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      2:       return mtg_pkg::word_t'($urandom_range(1, 16));
      3:       return mtg_pkg::word_t'(32'd1 << $urandom_range(0, 31));
      default: return mtg_pkg::word_t'($urandom());
    endcase
  endfunction

  function automatic mtg_pkg::word_t pick_seed();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      default: return mtg_pkg::word_t'($urandom());
    endcase
  endfunction

  task automatic draw_run(int unsigned count);
    repeat (count) offer_item(mtg_pkg::ACT_DRAW, mtg_pkg::word_t'($urandom()),
                              pick_limit());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned pick;
    int unsigned drain;

    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.action      = mtg_pkg::ACT_DRAW;
    in_chan.seed_value  = '0;
    in_chan.range_limit = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // draws before any seed: zero word, flag set, pool untouched
    offer_item(mtg_pkg::ACT_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0000);

    // all-zero seed, then range extremes incl. zero limit
    offer_item(mtg_pkg::ACT_SEED, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0000);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0001);
    offer_item(mtg_pkg::ACT_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h8000_0000);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0002);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_000A);

    // all-ones seed in the middle of a stream
    offer_item(mtg_pkg::ACT_SEED, 32'hFFFF_FFFF, 32'h0000_0000);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0000);

    // back-to-back reseed with no draw in between
    offer_item(mtg_pkg::ACT_SEED, 32'h0000_0001, 32'h0000_0000);
    offer_item(mtg_pkg::ACT_SEED, 32'h8000_0000, 32'h0000_0000);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0006);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'h0000_0064);
    offer_item(mtg_pkg::ACT_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);

    items_sent = 0;

    // long stream to or past the 624-word boundary, where the pool regenerates;
    // the sink stalls hard at its start
    offer_item(mtg_pkg::ACT_SEED, pick_seed(), pick_limit());
    hold_request = 1'b1;
    draw_run(mtg_pkg::MT_WORDS + $urandom_range(0, 12));

    // mostly seed-then-draws runs, plus bare reseeds and continued streams
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= ITEM_GOAL - QUIET_TAIL) idle_enabled = 1'b0;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        offer_item(mtg_pkg::ACT_SEED, pick_seed(), pick_limit());
      end else if (pick < 8) begin
        offer_item(mtg_pkg::ACT_SEED, pick_seed(), pick_limit());
        draw_run($urandom_range(1, 40));
      end else begin
        draw_run($urandom_range(1, 20));
      end
    end
    offer_item(mtg_pkg::ACT_DRAW, mtg_pkg::word_t'($urandom()), pick_limit());
    in_chan.valid <= 1'b0;

    // drain: wait for every expected draw, then a few cycles for strays
    drain = 0;
    while (board.pending() != 0 && drain < DRAIN_CAP) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected results never arrived", board.pending());
      board.mismatches++;
    end

    $display("Run: %0d seeds, %0d draws checked (%0d unseeded, %0d zero limit).",
             board.seeds_taken, board.draws_checked, board.unseeded_draws,
             board.zero_limits);
    $display("Pool regenerated %0d times past the 624-word mark; %0d mismatches.",
             board.wraps, board.mismatches);
    if (board.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
